// ===== sv/ptds_pkg.sv =====
// shared types and constants of the periodic task due scheduler
package ptds_pkg;

  localparam int unsigned NumHwSlots = 4;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned ActiveW    = 3;
  localparam int unsigned CfgIdxW    = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE  = 3'd0,
    CFG_PERIOD0 = 3'd1,
    CFG_PERIOD1 = 3'd2,
    CFG_PERIOD2 = 3'd3,
    CFG_PERIOD3 = 3'd4
  } cfg_idx_e;

  typedef logic [TimeW-1:0] time_ms_t;

  typedef struct packed {
    logic enable;
    logic advance;
  } slot_ctrl_t;

endpackage

// ===== sv/ptds_slot.sv =====
// one task slot: last-run register and due check
module ptds_slot (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptds_pkg::slot_ctrl_t ctrl_i,
  input  ptds_pkg::time_ms_t  period_i,
  input  ptds_pkg::time_ms_t  now_i,
  output logic                fire_o
);
  import ptds_pkg::*;

  time_ms_t last_run_q;
  time_ms_t last_run_d;
  time_ms_t due_at;

  // sum wraps modulo 2^32
  assign due_at = last_run_q + period_i;
  assign fire_o = ctrl_i.enable && ((last_run_q == '0) || (due_at <= now_i));

  always_comb begin
    last_run_d = last_run_q;
    if (ctrl_i.advance && fire_o) begin
      last_run_d = now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_run_q <= '0;
    end else begin
      last_run_q <= last_run_d;
    end
  end

endmodule

// ===== sv/periodic_task_due_scheduler_top.sv =====
// top level of the periodic task due scheduler
// One request per scheduler pass carries now_ms; one fire_mask comes back per request, in order.
// A request is accepted every cycle when the result side keeps up; the input register loads at
// acceptance and the result register loads from it once the result side can take it, which
// makes fire_mask valid. Each active slot fires
// when its last-run time is zero or last-run plus period (wrapping at 32 bits) is at or below
// now_ms, and then stores now_ms. Slots at or above active_tasks (capped at TASK_SLOTS) never
// fire. Write configuration only while no request is in flight.
module periodic_task_due_scheduler_top #(
  parameter int unsigned TASK_SLOTS = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ptds_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ptds_pkg::TimeW-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ptds_pkg::TimeW-1:0]       now_ms_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ptds_pkg::NumHwSlots-1:0]  fire_mask_o
);
  import ptds_pkg::*;

  logic [ActiveW-1:0]    active_q;
  time_ms_t              period_q [TASK_SLOTS];
  logic                  in_valid_q;
  time_ms_t              now_q;
  logic                  out_valid_q;
  logic [NumHwSlots-1:0] mask_q;
  logic [NumHwSlots-1:0] mask_d;
  logic                  advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // active slot count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_we_i && (cfg_index_i == CFG_ACTIVE)) begin
      active_q <= cfg_wdata_i[ActiveW-1:0];
    end
  end

  for (genvar i = 0; i < NumHwSlots; i++) begin : g_slot
    if (i < TASK_SLOTS) begin : g_used
      slot_ctrl_t ctrl;
      logic       fire;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          period_q[i] <= '0;
        end else if (cfg_we_i &&
                     (cfg_index_i == (CfgIdxW'(CFG_PERIOD0) + CfgIdxW'(i)))) begin
          period_q[i] <= cfg_wdata_i;
        end
      end

      assign ctrl.enable  = (active_q > ActiveW'(i));
      assign ctrl.advance = advance;

      ptds_slot u_slot (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (ctrl),
        .period_i (period_q[i]),
        .now_i    (now_q),
        .fire_o   (fire)
      );

      assign mask_d[i] = fire;
    end else begin : g_unused
      assign mask_d[i] = 1'b0;
    end
  end

  // input and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      now_q <= now_ms_i;
    end
    if (advance) begin
      mask_q <= mask_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign fire_mask_o = mask_q;

endmodule

// ===== sv/ptds_checker.sv =====
// port-level assertions of the periodic task due scheduler and their bind
module ptds_checker #(
  parameter int unsigned TASK_SLOTS = 4
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] fire_mask_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fire_mask_o))
    else $error("result changed while stalled");

  // slots at or above TASK_SLOTS never fire
  a_mask_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((fire_mask_o >> TASK_SLOTS) == 4'd0))
    else $error("fire bit set on a missing slot");

  // input side only stalls behind a stalled result
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without result backpressure");

  // a fresh result comes from an earlier accepted request
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a request");

endmodule

bind periodic_task_due_scheduler_top ptds_checker #(
  .TASK_SLOTS(TASK_SLOTS)
) u_ptds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .fire_mask_o (fire_mask_o)
);

// ===== tb/sv/periodic_task_due_scheduler_top_test.sv =====
// self-checking testbench of the periodic task due scheduler with random passes and stalls
module periodic_task_due_scheduler_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ptds_pkg::*;

  localparam int unsigned SlotCnt      = 4;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned RandPhases   = 16;
  localparam int unsigned PassesPerPhase = 100;

  logic                  clk_i;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index = '0;
  time_ms_t              cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready_o;
  time_ms_t              now_ms    = '0;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  logic [NumHwSlots-1:0] fire_mask_o;

  // scheduler state and registers as the block should hold them
  logic [ActiveW-1:0]    cfg_active = '0;
  time_ms_t              slot_period [NumHwSlots] = '{default: '0};
  time_ms_t              last_run    [NumHwSlots] = '{default: '0};

  time_ms_t              pending_now_q [$];
  logic [NumHwSlots-1:0] due_mask_q [$];
  int unsigned           passes_queued = 0;
  int unsigned           masks_checked = 0;
  int unsigned           mismatch_cnt  = 0;
  int unsigned           cycle_cnt     = 0;

  periodic_task_due_scheduler_top #(
    .TASK_SLOTS(SlotCnt)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .now_ms_i   (now_ms),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .fire_mask_o(fire_mask_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic [NumHwSlots-1:0] run_scheduler_pass(time_ms_t now);
    logic [NumHwSlots-1:0] mask;
    int unsigned           n;
    time_ms_t              due_at;
    mask = '0;
    n = cfg_active;
    if (n > SlotCnt) n = SlotCnt;
    if (n > NumHwSlots) n = NumHwSlots;
    for (int i = 0; i < n; i++) begin
      due_at = last_run[i] + slot_period[i];
      if (last_run[i] == '0 || due_at <= now) begin
        last_run[i] = now;
        mask[i] = 1'b1;
      end
    end
    return mask;
  endfunction

  // caller is aligned to a rising edge; caller lowers the write enable afterwards
  task automatic write_reg(logic [CfgIdxW-1:0] idx, time_ms_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    case (idx)
      CFG_ACTIVE:  cfg_active = data[ActiveW-1:0];
      CFG_PERIOD0: slot_period[0] = data;
      CFG_PERIOD1: slot_period[1] = data;
      CFG_PERIOD2: slot_period[2] = data;
      CFG_PERIOD3: slot_period[3] = data;
      default: ;
    endcase
  endtask

  task automatic queue_pass(time_ms_t t);
    pending_now_q.push_back(t);
    passes_queued++;
  endtask

  task automatic drain();
    while (masks_checked != passes_queued) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic time_ms_t pick_period();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(1, 40);
      4:       return $urandom_range(41, 5000);
      default: return $urandom();
    endcase
  endfunction

  task automatic configure_random();
    logic [ActiveW-1:0] act;
    time_ms_t           d;
    if ($urandom_range(0, 3) != 0) begin
      act = ActiveW'($urandom_range(1, NumHwSlots));
    end else begin
      act = ActiveW'($urandom());
    end
    d = $urandom();
    d[ActiveW-1:0] = act;
    write_reg(CFG_ACTIVE, d);
    for (int s = 0; s < NumHwSlots; s++) begin
      write_reg(CfgIdxW'(int'(CFG_PERIOD0) + s), pick_period());
    end
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CfgIdxW'($urandom_range(int'(CFG_PERIOD3) + 1, (1 << CfgIdxW) - 1)),
                $urandom());
    end
    cfg_we <= 1'b0;
  endtask

  // mostly advancing time with random steps, some phases jump around
  task automatic queue_random_passes(int unsigned count);
    time_ms_t    t;
    int unsigned mode;
    mode = $urandom_range(0, 3);
    case ($urandom_range(0, 3))
      0:       t = '0;
      1:       t = '1 - $urandom_range(0, 600);
      default: t = $urandom();
    endcase
    for (int unsigned k = 0; k < count; k++) begin
      if (mode == 2) begin
        case ($urandom_range(0, 15))
          0:       t = '0;
          1:       t = '1;
          default: t = $urandom();
        endcase
      end else if (mode == 3 && $urandom_range(0, 7) == 0) begin
        t = $urandom();
      end else begin
        t = t + $urandom_range(0, 25);
      end
      queue_pass(t);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // active count above the slot count, zero and full-range periods
    write_reg(CFG_ACTIVE, '1);
    write_reg(CFG_PERIOD0, '0);
    write_reg(CFG_PERIOD1, 32'd1);
    write_reg(CFG_PERIOD2, '1);
    write_reg(CFG_PERIOD3, 32'd10);
    cfg_we <= 1'b0;
    queue_pass('0);
    queue_pass('0);
    queue_pass(32'd3);
    queue_pass(32'd3);
    queue_pass(32'd4);
    queue_pass(32'd13);
    queue_pass(32'd14);
    queue_pass('1);
    queue_pass(32'd9);
    queue_pass(32'h8000_0000);
    queue_pass(32'h8000_0000);
    drain();

    // unmapped indexes are ignored, no slots active
    for (int k = int'(CFG_PERIOD3) + 1; k < (1 << CfgIdxW); k++) begin
      write_reg(CfgIdxW'(k), '1);
    end
    write_reg(CFG_ACTIVE, 32'hFFFF_FFF8);
    cfg_we <= 1'b0;
    queue_pass(32'd5);
    queue_pass('1);
    drain();

    write_reg(CFG_ACTIVE, 32'd2);
    write_reg(CFG_PERIOD1, 32'h7FFF_FFFF);
    cfg_we <= 1'b0;
    queue_pass(32'h8000_0001);
    queue_pass(32'd2);
    queue_pass(32'h8000_0002);
    queue_pass('1);
    queue_pass('0);
    queue_pass('0);
    drain();

    repeat (RandPhases) begin
      configure_random();
      queue_random_passes(PassesPerPhase);
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // request driver, bursts with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        due_mask_q.push_back(run_scheduler_pass(now_ms));
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left > 0 || pending_now_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          now_ms   <= pending_now_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // result monitor with a rotating stall pattern
  logic [15:0] stall_pat = 16'hFFFF;
  int unsigned pat_age   = 0;

  always @(posedge clk_i) begin
    logic [NumHwSlots-1:0] exp_mask;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (due_mask_q.size() == 0) begin
          $display("%0t: unexpected fire_mask %h", $time, fire_mask_o);
          mismatch_cnt++;
        end else begin
          exp_mask = due_mask_q.pop_front();
          if (fire_mask_o !== exp_mask) begin
            $display("%0t: fire_mask expected %h actual %h", $time, exp_mask, fire_mask_o);
            mismatch_cnt++;
          end
          masks_checked++;
        end
      end
      if (pat_age == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat = 16'hFFFF;
          3:       stall_pat = 16'h0001;
          default: stall_pat = 16'($urandom()) | 16'h0001;
        endcase
        pat_age = 64;
      end
      pat_age--;
      out_ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// ===== files.f =====
sv/ptds_pkg.sv
sv/ptds_slot.sv
sv/periodic_task_due_scheduler_top.sv
sv/ptds_checker.sv
tb/sv/periodic_task_due_scheduler_top_test.sv
